// ===== sv/cmmd_pkg.sv =====
// Shared types and constants of the chunk min/max decimator.
`timescale 1ns / 1ps
`default_nettype none
package cmmd_pkg;

    localparam int INDEX_BITS  = 32;
    localparam int SAMPLE_BITS = 64;
    localparam int DATA_BITS   = 64;
    localparam int CFG_BITS    = 32;
    localparam int FILL_BITS   = 32;
    localparam int ADDR_BITS   = 3;
    localparam int CMP_BITS    = (INDEX_BITS > CFG_BITS) ? INDEX_BITS : CFG_BITS;
    localparam int KIND_COUNT  = 4;

    typedef enum logic [ADDR_BITS-1:0] {
        REG_CHUNK_SIZE     = 3'd0,
        REG_WINDOW_ENABLE  = 3'd1,
        REG_WINDOW_START   = 3'd2,
        REG_WINDOW_STOP    = 3'd3,
        REG_PAD_ENDPOINTS  = 3'd4,
        REG_SIGNED_COMPARE = 3'd5
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_FIRST = 2'd0,
        KIND_MIN   = 2'd1,
        KIND_MAX   = 2'd2,
        KIND_LAST  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] chunk_size;
        logic                window_enable;
        logic [CFG_BITS-1:0] window_start;
        logic [CFG_BITS-1:0] window_stop;
        logic                pad_endpoints;
        logic                signed_compare;
    } cfg_t;

    // pend bit k set means a result of kind k is still owed
    typedef struct packed {
        logic [KIND_COUNT-1:0]  pend;
        logic                   col_end;
        logic [SAMPLE_BITS-1:0] sample;
        logic [SAMPLE_BITS-1:0] min_val;
        logic [SAMPLE_BITS-1:0] max_val;
    } bundle_t;

endpackage
`default_nettype wire

// ===== sv/cmmd_step.sv =====
// Per-sample state update: window check, running extremes, chunk flush decision.
`timescale 1ns / 1ps
`default_nettype none
module cmmd_step
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              accept,
    input  wire [cmmd_pkg::SAMPLE_BITS-1:0]  sample,
    input  wire                              col_end,
    input  wire cmmd_pkg::cfg_t              cfg,
    output cmmd_pkg::bundle_t                bundle
);
    import cmmd_pkg::*;

    localparam logic [SAMPLE_BITS-1:0] SIGN_BIT  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [INDEX_BITS-1:0]  INDEX_MAX = '1;

    logic [INDEX_BITS-1:0]  sample_index_reg, sample_index_next;
    logic [FILL_BITS-1:0]   chunk_fill_reg,   chunk_fill_next;
    logic [SAMPLE_BITS-1:0] running_min_reg,  running_min_next;
    logic [SAMPLE_BITS-1:0] running_max_reg,  running_max_next;

    logic [SAMPLE_BITS-1:0] key_flip;
    logic [SAMPLE_BITS-1:0] key_x, key_min, key_max;
    logic [FILL_BITS-1:0]   size;
    logic [FILL_BITS-1:0]   fill_inc, fill_new;
    logic [CMP_BITS-1:0]    idx_w;
    logic                   idx_at_stop;
    logic                   in_window;
    logic                   flush;
    logic                   emit_pair;

    always_comb
    begin
        key_flip = cfg.signed_compare ? SIGN_BIT : '0;
        key_x    = sample ^ key_flip;
        key_min  = running_min_reg ^ key_flip;
        key_max  = running_max_reg ^ key_flip;

        size = (cfg.chunk_size == '0) ? FILL_BITS'(1) : FILL_BITS'(cfg.chunk_size);

        idx_w       = CMP_BITS'(sample_index_reg);
        idx_at_stop = (idx_w == CMP_BITS'(cfg.window_stop));
        in_window   = !cfg.window_enable
                      || ((idx_w >= CMP_BITS'(cfg.window_start))
                          && (idx_w <= CMP_BITS'(cfg.window_stop)));

        fill_inc         = chunk_fill_reg + FILL_BITS'(1);
        fill_new         = chunk_fill_reg;
        running_min_next = running_min_reg;
        running_max_next = running_max_reg;
        flush            = 1'b0;

        if (in_window)
        begin
            if (chunk_fill_reg == '0)
            begin
                running_min_next = sample;
                running_max_next = sample;
            end
            else if (key_x > key_max)
            begin
                running_max_next = sample;
            end
            else if (key_x < key_min)
            begin
                running_min_next = sample;
            end
            fill_new = fill_inc;
            if (fill_inc >= size || (cfg.window_enable && idx_at_stop))
            begin
                flush = 1'b1;
            end
        end
        if (col_end && fill_new != '0)
        begin
            flush = 1'b1;
        end
        emit_pair = flush && (fill_new != '0);

        chunk_fill_next = (emit_pair || col_end) ? '0 : fill_new;

        if (col_end)
        begin
            sample_index_next = '0;
        end
        else if (sample_index_reg < INDEX_MAX)
        begin
            sample_index_next = sample_index_reg + INDEX_BITS'(1);
        end
        else
        begin
            sample_index_next = sample_index_reg;
        end

        bundle.pend[KIND_FIRST] = cfg.pad_endpoints && (sample_index_reg == '0);
        bundle.pend[KIND_MIN]   = emit_pair;
        bundle.pend[KIND_MAX]   = emit_pair;
        bundle.pend[KIND_LAST]  = cfg.pad_endpoints && col_end;
        bundle.col_end          = col_end;
        bundle.sample           = sample;
        bundle.min_val          = running_min_next;
        bundle.max_val          = running_max_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_index_reg <= '0;
            chunk_fill_reg   <= '0;
            running_min_reg  <= '0;
            running_max_reg  <= '0;
        end
        else if (accept)
        begin
            sample_index_reg <= sample_index_next;
            chunk_fill_reg   <= chunk_fill_next;
            running_min_reg  <= running_min_next;
            running_max_reg  <= running_max_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/chunk_min_max_decimator_unit.sv =====
// Top level of the chunk min/max decimator: configuration, result buffer, output stream.
`timescale 1ns / 1ps
`default_nettype none
// Min/max decimator for plotting. Each sample request is folded into the
// running chunk extremes in the cycle it is taken, and the results it causes
// (first endpoint, chunk minimum, chunk maximum, last endpoint, in that order)
// go into a result buffer that drains one result per cycle on the master side
// while m_axis_tready is high. A request that causes more than one result holds
// the slave side until the buffer drains, set by the single output port. The next
// request is taken in the same cycle the buffer's final result leaves. Write
// configuration only while the block is idle.
module chunk_min_max_decimator_unit
(
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_wen,
    input  wire [cmmd_pkg::ADDR_BITS-1:0]   cfg_index,
    input  wire [cmmd_pkg::CFG_BITS-1:0]    cfg_data,
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire [cmmd_pkg::DATA_BITS-1:0]   s_axis_tdata,   // [63:0] sample_bits
    input  wire                             s_axis_tlast,   // column_end
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    output logic [cmmd_pkg::DATA_BITS-1:0]  m_axis_tdata,   // [63:0] result_value
    output logic                            m_axis_tlast,   // run_last
    output logic [2:0]                      m_axis_tuser    // [1:0] result_kind, [2] column_done
);
    import cmmd_pkg::*;

    cfg_t                   cfg_reg;
    logic [KIND_COUNT-1:0]  pend_reg;
    logic                   col_end_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] min_reg;
    logic [SAMPLE_BITS-1:0] max_reg;
    bundle_t                step_bundle;
    logic [KIND_COUNT-1:0]  pend_next;
    logic                   one_left;
    logic                   pop;
    logic                   accept;
    kind_t                  kind;
    logic [SAMPLE_BITS-1:0] value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chunk_size     <= CFG_BITS'(1);
            cfg_reg.window_enable  <= 1'b0;
            cfg_reg.window_start   <= '0;
            cfg_reg.window_stop    <= '0;
            cfg_reg.pad_endpoints  <= 1'b0;
            cfg_reg.signed_compare <= 1'b1;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_CHUNK_SIZE:     cfg_reg.chunk_size     <= cfg_data;
                REG_WINDOW_ENABLE:  cfg_reg.window_enable  <= cfg_data[0];
                REG_WINDOW_START:   cfg_reg.window_start   <= cfg_data;
                REG_WINDOW_STOP:    cfg_reg.window_stop    <= cfg_data;
                REG_PAD_ENDPOINTS:  cfg_reg.pad_endpoints  <= cfg_data[0];
                REG_SIGNED_COMPARE: cfg_reg.signed_compare <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    cmmd_step u_step
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .sample  (s_axis_tdata[SAMPLE_BITS-1:0]),
        .col_end (s_axis_tlast),
        .cfg     (cfg_reg),
        .bundle  (step_bundle)
    );

    always_comb
    begin
        one_left      = ((pend_reg & (pend_reg - KIND_COUNT'(1))) == '0);
        m_axis_tvalid = (pend_reg != '0);
        pop           = m_axis_tvalid && m_axis_tready;
        pend_next     = pend_reg & (pend_reg - KIND_COUNT'(1));
        s_axis_tready = !m_axis_tvalid || (m_axis_tready && one_left);
        accept        = s_axis_tvalid && s_axis_tready;

        if (pend_reg[KIND_FIRST])
        begin
            kind = KIND_FIRST;
        end
        else if (pend_reg[KIND_MIN])
        begin
            kind = KIND_MIN;
        end
        else if (pend_reg[KIND_MAX])
        begin
            kind = KIND_MAX;
        end
        else
        begin
            kind = KIND_LAST;
        end

        case (kind)
            KIND_MIN: value = min_reg;
            KIND_MAX: value = max_reg;
            default:  value = sample_reg;
        endcase

        m_axis_tdata = DATA_BITS'(value);
        m_axis_tlast = one_left;
        m_axis_tuser = {one_left && col_end_reg, kind};
    end

    // hold the pending mask under reset; payload follows the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (accept)
        begin
            pend_reg <= step_bundle.pend;
        end
        else if (pop)
        begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_end_reg <= step_bundle.col_end;
            sample_reg  <= step_bundle.sample;
            min_reg     <= step_bundle.min_val;
            max_reg     <= step_bundle.max_val;
        end
    end

endmodule
`default_nettype wire
